@@ hdl/lrbi_pkg.sv @@
// ----------------------------------------------------------------------------
// lrbi_pkg
// shared types and constants of the led ring bearing indicator
// ----------------------------------------------------------------------------
package lrbi_pkg;

  // angle unit: 1/16 degree, one full turn
  localparam int TURN      = 5760;
  localparam int HALF_TURN = 2880;

  localparam int NOW_W   = 32;
  localparam int ANGLE_W = 13;
  localparam int IDX_W   = 6;
  localparam int COLOR_W = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // mode register codes, the unused code behaves as direction display
  localparam logic [1:0] MODE_INPUT = 2'd0;
  localparam logic [1:0] MODE_PROC  = 2'd1;
  localparam logic [1:0] MODE_DIR   = 2'd2;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE           = 4'd0,
    CFG_MANUAL_BEARING = 4'd1,
    CFG_MANUAL_VALID   = 4'd2,
    CFG_NORTH_OFFSET   = 4'd3,
    CFG_BLINK_PERIOD   = 4'd4,
    CFG_PULSE_PERIOD   = 4'd5,
    CFG_PULSE_MIN      = 4'd6,
    CFG_PULSE_MAX      = 4'd7
  } cfg_idx_t;

  localparam logic [COLOR_W-1:0] GREEN_ARRIVE = 8'd128;
  localparam logic [COLOR_W-1:0] BLUE_FULL    = 8'd255;
  localparam logic [COLOR_W-1:0] BLUE_DIM     = 8'd64;
  localparam logic [COLOR_W-1:0] COLOR_OFF    = 8'd0;

  typedef struct packed {
    logic [1:0]         mode;
    logic [ANGLE_W-1:0] manual_bearing;
    logic               manual_bearing_valid;
    logic [IDX_W-1:0]   north_offset;
    logic [15:0]        blink_period_ms;
    logic [15:0]        pulse_period_ms;
    logic [COLOR_W-1:0] pulse_min;
    logic [COLOR_W-1:0] pulse_max;
  } cfg_t;

  // frame description handed from tick stage to frame streamer
  typedef struct packed {
    logic               dir;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [ANGLE_W-1:0] rel;
  } frame_t;

endpackage

@@ hdl/lrbi_ifs.sv @@
// ----------------------------------------------------------------------------
// lrbi channel interfaces
// tick input, led result and configuration write channels
// ----------------------------------------------------------------------------
interface lrbi_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        arrived;
  logic        heading_valid;
  logic [12:0] heading;
  logic        gps_bearing_valid;
  logic [12:0] gps_bearing;

  modport source (
    output valid, now_ms, arrived, heading_valid, heading, gps_bearing_valid,
           gps_bearing,
    input  ready
  );
  modport sink (
    input  valid, now_ms, arrived, heading_valid, heading, gps_bearing_valid,
           gps_bearing,
    output ready
  );
endinterface

interface lrbi_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] led_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_led;

  modport source (
    output valid, led_index, red, green, blue, last_led,
    input  ready
  );
  modport sink (
    input  valid, led_index, red, green, blue, last_led,
    output ready
  );
endinterface

interface lrbi_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/lrbi_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// lrbi_cfg_regs
// configuration register file, one write per word, unknown indexes ignored
// ----------------------------------------------------------------------------
module lrbi_cfg_regs
  import lrbi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE:           cfg_nxt.mode                 = cfg_data[1:0];
        CFG_MANUAL_BEARING: cfg_nxt.manual_bearing       = cfg_data[ANGLE_W-1:0];
        CFG_MANUAL_VALID:   cfg_nxt.manual_bearing_valid = cfg_data[0];
        CFG_NORTH_OFFSET:   cfg_nxt.north_offset         = cfg_data[IDX_W-1:0];
        CFG_BLINK_PERIOD:   cfg_nxt.blink_period_ms      = cfg_data;
        CFG_PULSE_PERIOD:   cfg_nxt.pulse_period_ms      = cfg_data;
        CFG_PULSE_MIN:      cfg_nxt.pulse_min            = cfg_data[COLOR_W-1:0];
        CFG_PULSE_MAX:      cfg_nxt.pulse_max            = cfg_data[COLOR_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode                 <= MODE_INPUT;
      cfg_r.manual_bearing       <= '0;
      cfg_r.manual_bearing_valid <= 1'b0;
      cfg_r.north_offset         <= '0;
      cfg_r.blink_period_ms      <= 16'd500;
      cfg_r.pulse_period_ms      <= 16'd20;
      cfg_r.pulse_min            <= 8'd0;
      cfg_r.pulse_max            <= 8'd255;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hdl/lrbi_tick.sv @@
// ----------------------------------------------------------------------------
// lrbi_tick
// input register, blink and pulse state update, pattern choice per tick
// ----------------------------------------------------------------------------
module lrbi_tick
  import lrbi_pkg::*;
#(
  parameter int PULSE_STEP = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [NOW_W-1:0]   in_now_ms,
  input  logic               in_arrived,
  input  logic               in_heading_valid,
  input  logic [ANGLE_W-1:0] in_heading,
  input  logic               in_gps_bearing_valid,
  input  logic [ANGLE_W-1:0] in_gps_bearing,
  output logic               tick_valid,
  input  logic               tick_ready,
  output frame_t             tick_frame
);

  localparam logic signed [9:0]  STEP_S = 10'(PULSE_STEP);
  localparam logic signed [14:0] TURN_S = 15'(TURN);

  // input register
  logic               s1_valid_r;
  logic [NOW_W-1:0]   now_r;
  logic               arrived_r;
  logic               hv_r;
  logic [ANGLE_W-1:0] heading_r;
  logic               gv_r;
  logic [ANGLE_W-1:0] gps_r;

  // tick state
  logic               blink_on_r, blink_on_nxt;
  logic [NOW_W-1:0]   blink_stamp_r, blink_stamp_nxt;
  logic [NOW_W-1:0]   pulse_stamp_r, pulse_stamp_nxt;
  logic [COLOR_W-1:0] pulse_level_r, pulse_level_nxt;
  logic               in_falling_r, in_falling_nxt;
  logic               proc_falling_r, proc_falling_nxt;

  // frame stage
  logic   s2_valid_r;
  frame_t frame_r, frame_nxt;

  logic               s2_ready, take;
  logic [NOW_W-1:0]   blink_el, pulse_el;
  logic               fall_cur, fall_step;
  logic signed [9:0]  pulse_sum;
  logic [COLOR_W-1:0] level_step;
  logic [ANGLE_W-1:0] base;
  logic signed [14:0] diff;
  logic signed [14:0] rel_s;

  assign s2_ready   = !s2_valid_r || tick_ready;
  assign take       = s1_valid_r && s2_ready;
  assign in_ready   = !s1_valid_r || s2_ready;
  assign tick_valid = s2_valid_r;
  assign tick_frame = frame_r;

  // pulse step shared by both pulse modes, each with its own direction
  always_comb begin
    blink_el = now_r - blink_stamp_r;
    pulse_el = now_r - pulse_stamp_r;
    fall_cur = (cfg.mode == MODE_INPUT) ? in_falling_r : proc_falling_r;
    pulse_sum = $signed({2'b00, pulse_level_r}) + (fall_cur ? -STEP_S : STEP_S);
    fall_step  = fall_cur;
    level_step = pulse_level_r;
    if (pulse_sum >= $signed({2'b00, cfg.pulse_max})) begin
      level_step = cfg.pulse_max;
      fall_step  = 1'b1;
    end else if (pulse_sum <= $signed({2'b00, cfg.pulse_min})) begin
      level_step = cfg.pulse_min;
      fall_step  = 1'b0;
    end else begin
      level_step = pulse_sum[COLOR_W-1:0];
    end
  end

  // relative bearing folded into one turn
  always_comb begin
    base = gv_r ? gps_r : cfg.manual_bearing;
    diff = $signed({2'b00, base}) - $signed({2'b00, heading_r});
    priority if (diff >= TURN_S) begin
      rel_s = diff - TURN_S;
    end else if (diff >= 15'sd0) begin
      rel_s = diff;
    end else if (diff >= -TURN_S) begin
      rel_s = diff + TURN_S;
    end else begin
      rel_s = diff + TURN_S + TURN_S;
    end
  end

  always_comb begin
    blink_on_nxt     = blink_on_r;
    blink_stamp_nxt  = blink_stamp_r;
    pulse_stamp_nxt  = pulse_stamp_r;
    pulse_level_nxt  = pulse_level_r;
    in_falling_nxt   = in_falling_r;
    proc_falling_nxt = proc_falling_r;
    frame_nxt.dir    = 1'b0;
    frame_nxt.red    = COLOR_OFF;
    frame_nxt.green  = COLOR_OFF;
    frame_nxt.blue   = COLOR_OFF;
    frame_nxt.rel    = rel_s[ANGLE_W-1:0];
    priority if (arrived_r) begin
      if (blink_el > {16'd0, cfg.blink_period_ms}) begin
        blink_on_nxt    = !blink_on_r;
        blink_stamp_nxt = now_r;
      end
      frame_nxt.green = blink_on_nxt ? GREEN_ARRIVE : COLOR_OFF;
    end else if (cfg.mode == MODE_INPUT || cfg.mode == MODE_PROC) begin
      if (pulse_el > {16'd0, cfg.pulse_period_ms}) begin
        pulse_stamp_nxt = now_r;
        pulse_level_nxt = level_step;
        if (cfg.mode == MODE_INPUT) begin
          in_falling_nxt = fall_step;
        end else begin
          proc_falling_nxt = fall_step;
        end
      end
      frame_nxt.green = pulse_level_nxt;
      frame_nxt.red   = (cfg.mode == MODE_PROC) ? pulse_level_nxt : COLOR_OFF;
    end else if (hv_r && (gv_r || cfg.manual_bearing_valid)) begin
      frame_nxt.dir = 1'b1;
    end else begin
      frame_nxt.blue = BLUE_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      s2_valid_r     <= 1'b0;
      blink_on_r     <= 1'b0;
      blink_stamp_r  <= '0;
      pulse_stamp_r  <= '0;
      pulse_level_r  <= '0;
      in_falling_r   <= 1'b0;
      proc_falling_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (take) begin
        blink_on_r     <= blink_on_nxt;
        blink_stamp_r  <= blink_stamp_nxt;
        pulse_stamp_r  <= pulse_stamp_nxt;
        pulse_level_r  <= pulse_level_nxt;
        in_falling_r   <= in_falling_nxt;
        proc_falling_r <= proc_falling_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      now_r     <= in_now_ms;
      arrived_r <= in_arrived;
      hv_r      <= in_heading_valid;
      heading_r <= in_heading;
      gv_r      <= in_gps_bearing_valid;
      gps_r     <= in_gps_bearing;
    end
    if (take) begin
      frame_r <= frame_nxt;
    end
  end

endmodule

@@ hdl/lrbi_frame.sv @@
// ----------------------------------------------------------------------------
// lrbi_frame
// bearing to led index, frame register and led streamer
// ----------------------------------------------------------------------------
module lrbi_frame
  import lrbi_pkg::*;
#(
  parameter int LED_COUNT = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [IDX_W-1:0]   north_offset,
  input  logic               tick_valid,
  output logic               tick_ready,
  input  frame_t             tick_frame,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [IDX_W-1:0]   out_led_index,
  output logic [COLOR_W-1:0] out_red,
  output logic [COLOR_W-1:0] out_green,
  output logic [COLOR_W-1:0] out_blue,
  output logic               out_last_led
);

  localparam int CW = $clog2(LED_COUNT);
  // floor(x / TURN) as (x * RECIP) >> 32, exact for x below 2^19
  localparam longint unsigned RECIP = ((64'd1 << 32) + 64'(TURN - 1)) / 64'(TURN);
  localparam longint unsigned SCALE = 64'(LED_COUNT) * RECIP;
  localparam longint unsigned BIAS  = 64'(HALF_TURN) * RECIP;
  localparam logic [CW-1:0] LAST = CW'(LED_COUNT - 1);

  logic [CW-1:0] off_tab [64];
  genvar k;
  generate
    for (k = 0; k < 64; k++) begin : g_off
      assign off_tab[k] = CW'(k % LED_COUNT);
    end
  endgenerate

  logic               frame_valid_r;
  logic [CW-1:0]      cnt_r;
  logic               dir_r;
  logic [COLOR_W-1:0] red_r, green_r, blue_r;
  logic [CW-1:0]      center_r, plus_r, minus_r;

  logic [39:0]   prod;
  logic [7:0]    quot;
  logic [CW-1:0] idx;
  logic [CW:0]   sum;
  logic [CW-1:0] center_nxt, plus_nxt, minus_nxt;
  logic          out_fire, last_fire, load;

  always_comb begin
    prod = {27'd0, tick_frame.rel} * SCALE[39:0] + BIAS[39:0];
    quot = prod[39:32];
    idx  = (quot == 8'(LED_COUNT)) ? '0 : quot[CW-1:0];
    sum  = {1'b0, idx} + {1'b0, off_tab[north_offset]};
    center_nxt = (sum >= (CW+1)'(LED_COUNT)) ? CW'(sum - (CW+1)'(LED_COUNT))
                                             : sum[CW-1:0];
    plus_nxt   = (center_nxt == LAST) ? '0 : center_nxt + 1'b1;
    minus_nxt  = (center_nxt == '0) ? LAST : center_nxt - 1'b1;
  end

  assign out_fire   = frame_valid_r && out_ready;
  assign last_fire  = out_fire && (cnt_r == LAST);
  assign tick_ready = !frame_valid_r || last_fire;
  assign load       = tick_valid && tick_ready;

  assign out_valid     = frame_valid_r;
  assign out_led_index = IDX_W'(cnt_r);
  assign out_last_led  = (cnt_r == LAST);
  assign out_red       = red_r;
  assign out_green     = green_r;

  always_comb begin
    if (!dir_r) begin
      out_blue = blue_r;
    end else if (cnt_r == center_r) begin
      out_blue = BLUE_FULL;
    end else if (cnt_r == plus_r || cnt_r == minus_r) begin
      out_blue = BLUE_DIM;
    end else begin
      out_blue = COLOR_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= 1'b0;
      cnt_r         <= '0;
    end else begin
      if (tick_ready) begin
        frame_valid_r <= tick_valid;
      end
      if (load || last_fire) begin
        cnt_r <= '0;
      end else if (out_fire) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dir_r    <= tick_frame.dir;
      red_r    <= tick_frame.red;
      green_r  <= tick_frame.green;
      blue_r   <= tick_frame.blue;
      center_r <= center_nxt;
      plus_r   <= plus_nxt;
      minus_r  <= minus_nxt;
    end
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    frame_valid_r |-> cnt_r <= LAST)
    else $error("led counter beyond ring");

  a_cnt_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    last_fire |=> cnt_r == '0)
    else $error("led counter did not restart after last led");

  a_neighbors: assert property (@(posedge clk) disable iff (!rst_n)
    (frame_valid_r && dir_r) |-> (center_r != plus_r && center_r != minus_r))
    else $error("bearing neighbor coincides with center");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (frame_valid_r && !last_fire) |=> frame_valid_r)
    else $error("frame dropped before last led");
`endif

endmodule

@@ hdl/led_ring_bearing_indicator.sv @@
// ----------------------------------------------------------------------------
// led_ring_bearing_indicator
// turns each tick into one frame of led colors: arrival blink, input or
// processing pulse, relative bearing pointer or solid blue
// ----------------------------------------------------------------------------
//  channel  dir  handshake        word
//  in_if    in   valid / ready    one tick: time, arrival, heading, bearing
//  out_if   out  valid / ready    one led: index, red, green, blue, last flag
//  cfg_if   in   valid / ready    one register write: index, data
//
//  each tick yields LED_COUNT words, one per cycle while out_if.ready is
//  high, so the output port sets the sustained rate
//  the first led of a frame appears after the tick passes the input
//  register, then the tick result register, then the frame register; the
//  next tick is taken while a frame is still streaming
//  reset is synchronous and active low; cfg_if is always ready
//  out_if.ready low freezes the led counter, the stages behind it fill and
//  then in_if.ready drops
// ----------------------------------------------------------------------------
module led_ring_bearing_indicator
  import lrbi_pkg::*;
#(
  parameter int LED_COUNT  = 16,
  parameter int PULSE_STEP = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  lrbi_in_if.sink    in_if,
  lrbi_out_if.source out_if,
  lrbi_cfg_if.sink   cfg_if
);

  cfg_t   cfg;
  logic   tick_valid;
  logic   tick_ready;
  frame_t tick_frame;

  // register file, a write is registered and shows on cfg in the cycle after it is taken
  lrbi_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_if.valid),
    .cfg_ready (cfg_if.ready),
    .cfg_index (cfg_if.index),
    .cfg_data  (cfg_if.data),
    .cfg       (cfg)
  );

  // tick register and per-tick state: blink toggle, shared pulse level
  lrbi_tick #(
    .PULSE_STEP (PULSE_STEP)
  ) u_tick (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg),
    .in_valid             (in_if.valid),
    .in_ready             (in_if.ready),
    .in_now_ms            (in_if.now_ms),
    .in_arrived           (in_if.arrived),
    .in_heading_valid     (in_if.heading_valid),
    .in_heading           (in_if.heading),
    .in_gps_bearing_valid (in_if.gps_bearing_valid),
    .in_gps_bearing       (in_if.gps_bearing),
    .tick_valid           (tick_valid),
    .tick_ready           (tick_ready),
    .tick_frame           (tick_frame)
  );

  // bearing to led index, then one word per led
  lrbi_frame #(
    .LED_COUNT (LED_COUNT)
  ) u_frame (
    .clk           (clk),
    .rst_n         (rst_n),
    .north_offset  (cfg.north_offset),
    .tick_valid    (tick_valid),
    .tick_ready    (tick_ready),
    .tick_frame    (tick_frame),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_led_index (out_if.led_index),
    .out_red       (out_if.red),
    .out_green     (out_if.green),
    .out_blue      (out_if.blue),
    .out_last_led  (out_if.last_led)
  );

endmodule
